// ===== rtl/core/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and constants for the PCI configuration space enumerator.
// ----------------------------------------------------------------------------
package pce_pkg;

  // Result kinds
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_REC  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CLASS    = 2'd0;
  localparam logic [1:0] CFG_SUBCLASS = 2'd1;
  localparam logic [1:0] CFG_PROGIF   = 2'd2;
  localparam logic [1:0] CFG_STOP     = 2'd3;

  // Configuration dword offsets
  localparam logic [7:0] OFF_ID    = 8'h00;
  localparam logic [7:0] OFF_CLASS = 8'h08;
  localparam logic [7:0] OFF_HDR   = 8'h0C;

  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
  localparam logic [7:0]  FILT_ANY    = 8'hFF;
  localparam logic [4:0]  LAST_SLOT   = 5'd31;
  localparam logic [7:0]  LAST_BUS    = 8'd255;
  localparam logic [3:0]  FUNC_SINGLE = 4'd1;
  localparam logic [3:0]  FUNC_MULTI  = 4'd8;
  localparam int unsigned HDR_MF_BIT  = 23;  // bit 7 of header type in dword 0x0C
  localparam logic [16:0] CNT_MAX     = 17'h1FFFF;

  // Output queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_F0ID  = 3'd1,
    PH_F0HDR = 3'd2,
    PH_FNID  = 3'd3,
    PH_FNCLS = 3'd4,
    PH_FNHDR = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef struct packed {
    logic        action;
    logic [31:0] read_data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  bus_number;
    logic [4:0]  slot_number;
    logic [2:0]  function_number;
    logic [7:0]  register_offset;
    logic [15:0] vendor_code;
    logic [15:0] device_code;
    logic [31:0] class_register;
    logic [7:0]  hdr_byte;
    logic [16:0] device_count;
  } out_word_t;

  typedef struct packed {
    logic [7:0] class_filter;
    logic [7:0] subclass_filter;
    logic [7:0] progif_filter;
    logic       stop_on_first;
  } cfg_t;

  // Up to two result words per response
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  r0;
    out_word_t  r1;
  } res_t;

endpackage

// ===== rtl/core/pce_seq.sv =====
// ----------------------------------------------------------------------------
// pce_seq
// Scan sequencer: holds the scan position and turns one input word into
// zero, one or two result words combinationally.
// ----------------------------------------------------------------------------
module pce_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  pce_pkg::in_word_t word,
  input  pce_pkg::cfg_t     cfg,
  output pce_pkg::res_t     res
);
  import pce_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  bus_r, bus_nxt;
  logic [4:0]  slot_r, slot_nxt;
  logic [2:0]  func_r, func_nxt;
  logic [3:0]  limit_r, limit_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] class_r, class_nxt;
  logic [16:0] count_r, count_nxt;

  logic        go_func, go_slot, rec, tail, done;
  logic [7:0]  tail_off;
  logic        match;
  out_word_t   rec_w, tail_w;

  // Filter compare on the stored class dword
  assign match = (cfg.class_filter == FILT_ANY || cfg.class_filter == class_r[31:24]) &&
                 (cfg.subclass_filter == FILT_ANY ||
                  cfg.subclass_filter == class_r[23:16]) &&
                 (cfg.progif_filter == FILT_ANY || cfg.progif_filter == class_r[15:8]);

  // Next state and result flags
  always_comb begin
    phase_nxt = phase_r;
    bus_nxt   = bus_r;
    slot_nxt  = slot_r;
    func_nxt  = func_r;
    limit_nxt = limit_r;
    id_nxt    = id_r;
    class_nxt = class_r;
    count_nxt = count_r;
    go_func   = 1'b0;
    go_slot   = 1'b0;
    rec       = 1'b0;
    tail      = 1'b0;
    done      = 1'b0;
    tail_off  = OFF_ID;
    if (step) begin
      if (!word.action) begin
        bus_nxt   = '0;
        slot_nxt  = '0;
        func_nxt  = '0;
        limit_nxt = FUNC_SINGLE;
        count_nxt = '0;
        phase_nxt = PH_F0ID;
        tail      = 1'b1;
      end else begin
        case (phase_r)
          PH_F0ID: begin
            if (word.read_data[15:0] == VENDOR_NONE) begin
              go_slot = 1'b1;
            end else begin
              phase_nxt = PH_F0HDR;
              tail      = 1'b1;
              tail_off  = OFF_HDR;
            end
          end
          PH_F0HDR: begin
            limit_nxt = word.read_data[HDR_MF_BIT] ? FUNC_MULTI : FUNC_SINGLE;
            func_nxt  = '0;
            phase_nxt = PH_FNID;
            tail      = 1'b1;
          end
          PH_FNID: begin
            if (word.read_data[15:0] == VENDOR_NONE) begin
              go_func = 1'b1;
            end else begin
              id_nxt    = word.read_data;
              phase_nxt = PH_FNCLS;
              tail      = 1'b1;
              tail_off  = OFF_CLASS;
            end
          end
          PH_FNCLS: begin
            class_nxt = word.read_data;
            phase_nxt = PH_FNHDR;
            tail      = 1'b1;
            tail_off  = OFF_HDR;
          end
          PH_FNHDR: begin
            if (match) begin
              rec = 1'b1;
              if (count_r != CNT_MAX) count_nxt = count_r + 17'd1;
            end
            if (match && cfg.stop_on_first) begin
              phase_nxt = PH_DONE;
              tail      = 1'b1;
              done      = 1'b1;
            end else begin
              go_func = 1'b1;
            end
          end
          default: ;
        endcase
      end

      // Advance to the next function, or fall through to the next slot
      if (go_func) begin
        if ({1'b0, func_r} + 4'd1 < limit_r) begin
          func_nxt  = func_r + 3'd1;
          phase_nxt = PH_FNID;
          tail      = 1'b1;
        end else begin
          go_slot = 1'b1;
        end
      end

      // Advance to the next slot and bus; the last bus ends the scan
      if (go_slot) begin
        func_nxt = '0;
        tail     = 1'b1;
        if (slot_r == LAST_SLOT) begin
          slot_nxt = '0;
          if (bus_r == LAST_BUS) begin
            bus_nxt   = '0;
            phase_nxt = PH_DONE;
            done      = 1'b1;
          end else begin
            bus_nxt   = bus_r + 8'd1;
            phase_nxt = PH_F0ID;
          end
        end else begin
          slot_nxt  = slot_r + 5'd1;
          phase_nxt = PH_F0ID;
        end
      end
    end
  end

  // Result words
  always_comb begin
    rec_w                 = '0;
    rec_w.kind            = KIND_REC;
    rec_w.bus_number      = bus_r;
    rec_w.slot_number     = slot_r;
    rec_w.function_number = func_r;
    rec_w.vendor_code     = id_r[15:0];
    rec_w.device_code     = id_r[31:16];
    rec_w.class_register  = class_r;
    rec_w.hdr_byte        = word.read_data[23:16];

    tail_w = '0;
    if (done) begin
      tail_w.kind         = KIND_DONE;
      tail_w.device_count = count_nxt;
    end else begin
      tail_w.kind            = KIND_REQ;
      tail_w.bus_number      = bus_nxt;
      tail_w.slot_number     = slot_nxt;
      tail_w.function_number = func_nxt;
      tail_w.register_offset = tail_off;
    end

    res.r0  = rec ? rec_w : tail_w;
    res.r1  = tail_w;
    res.cnt = {1'b0, rec} + {1'b0, tail};
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bus_r   <= '0;
      slot_r  <= '0;
      func_r  <= '0;
      limit_r <= FUNC_SINGLE;
      id_r    <= '0;
      class_r <= '0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      bus_r   <= bus_nxt;
      slot_r  <= slot_nxt;
      func_r  <= func_nxt;
      limit_r <= limit_nxt;
      id_r    <= id_nxt;
      class_r <= class_nxt;
      count_r <= count_nxt;
    end
  end

  // A response outside a scan gives nothing
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step && word.action && (phase_r == PH_IDLE || phase_r == PH_DONE)) |-> res.cnt == 2'd0)
    else $error("result produced outside a scan");

  // Two words only as a device record followed by a request or done
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (res.cnt == 2'd2) |-> (res.r0.kind == KIND_REC && res.r1.kind != KIND_REC))
    else $error("bad result pair");

  // Function limit is single or multi
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (limit_r == FUNC_SINGLE || limit_r == FUNC_MULTI))
    else $error("function limit corrupted");

endmodule

// ===== rtl/core/pce_outq.sv =====
// ----------------------------------------------------------------------------
// pce_outq
// Result queue: up to two words in per cycle, one out per unstalled cycle.
// ----------------------------------------------------------------------------
module pce_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  pce_pkg::res_t      res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output pce_pkg::out_word_t out_word
);
  import pce_pkg::*;

  out_word_t          q_r [OQ_DEPTH];
  logic [OQ_AW-1:0]   wr_r, rd_r;
  logic [OQ_AW:0]     count_r, count_nxt;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign out_word  = q_r[rd_r];
  assign pop       = out_valid && !out_stall;
  // room for a two-word push
  assign room      = (count_r <= (OQ_AW + 1)'(OQ_DEPTH - 2));

  assign count_nxt = count_r + {{(OQ_AW - 1){1'b0}}, res.cnt} - {{OQ_AW{1'b0}}, pop};

  // Storage writes
  always_ff @(posedge clk) begin
    if (res.cnt != 2'd0) q_r[wr_r] <= res.r0;
    if (res.cnt == 2'd2) q_r[wr_r + OQ_AW'(1)] <= res.r1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_r + OQ_AW'(res.cnt);
      rd_r    <= rd_r + OQ_AW'(pop);
      count_r <= count_nxt;
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (OQ_AW + 1)'(OQ_DEPTH))
    else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (res.cnt != 2'd0) |-> room)
    else $error("push without room");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r == $past(count_nxt))
    else $error("queue count mismatch");

endmodule

// ===== rtl/core/pci_config_enumerator.sv =====
// ----------------------------------------------------------------------------
// pci_config_enumerator
// PCI configuration space scan sequencer with class filters.
// ----------------------------------------------------------------------------
// Start a scan with an action 0 word; the block answers with configuration
// read requests and takes each read response as the next input word. Device
// records appear for functions that pass the class/subclass/prog-if filters,
// and a done word carrying the record count ends the scan. A word enters an
// input register, is processed from there once the queue has room, and its
// results are written into a four-deep output queue. One word per cycle is
// sustained while each word gives one result and the output is not stalled;
// a matching record followed by its request or done puts two words in the
// queue, which drains one per cycle while the output is not stalled, so the
// queue output port sets the pace for such a word. Input is stalled while the
// queue has fewer than two free entries. The user must write configuration
// only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module pci_config_enumerator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pce_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output pce_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import pce_pkg::*;

  logic     in_vld_r;
  in_word_t in_word_r;
  cfg_t     cfg_r;
  logic     room, step;
  res_t     res;

  assign step     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_word_r <= in_word;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.class_filter    <= FILT_ANY;
      cfg_r.subclass_filter <= FILT_ANY;
      cfg_r.progif_filter   <= FILT_ANY;
      cfg_r.stop_on_first   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLASS:    cfg_r.class_filter    <= cfg_wdata;
        CFG_SUBCLASS: cfg_r.subclass_filter <= cfg_wdata;
        CFG_PROGIF:   cfg_r.progif_filter   <= cfg_wdata;
        CFG_STOP:     cfg_r.stop_on_first   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pce_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .word  (in_word_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  pce_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== bench/tb_pci_config_enumerator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pci_config_enumerator
// Self-checking bench for the PCI configuration space scan sequencer.
// ----------------------------------------------------------------------------
// The bench plays the configuration bus. It answers each read request from a
// random device population that it generates on the fly. A predictor tracks
// the scan state and queues the request, record and done words that each
// accepted input word must produce. A receiver process compares every output
// word with the oldest queued word, field by field. Covered: responses while
// idle or done, directed walks through single and multi-function devices,
// filter misses and stop on first match, a restart mid scan, random traffic
// under several filter settings, and long output back-pressure.
// ----------------------------------------------------------------------------
module tb_pci_config_enumerator;
  import pce_pkg::*;

  localparam int          CLK_PERIOD    = 8;
  localparam int          RESET_CYCLES  = 7;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          LIMIT_CYCLES  = 400_000;
  localparam int          CFG_EVERY     = 100;
  localparam logic        ACT_START     = 1'b0;
  localparam logic        ACT_REPLY     = 1'b1;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_word_t   in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = CFG_CLASS;
  logic [7:0] cfg_wdata = '0;

  // Idle rates and receiver hold-off request
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_len     = 0;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  // Predicted scan state
  phase_t      sc_ph        = PH_IDLE;
  logic [7:0]  sc_bus       = '0;
  logic [4:0]  sc_slot      = '0;
  logic [2:0]  sc_func      = '0;
  logic [3:0]  sc_func_lim  = FUNC_SINGLE;
  logic [31:0] sc_id        = '0;
  logic [31:0] sc_class     = '0;
  logic [16:0] sc_count     = '0;
  cfg_t        scan_cfg     = '{FILT_ANY, FILT_ANY, FILT_ANY, 1'b0};

  // Words the block still owes us, oldest first
  out_word_t   awaited_q[$];

  // Run statistics
  int err_cnt     = 0;
  int words_sent  = 0;
  int n_req       = 0;
  int n_rec       = 0;
  int n_done      = 0;
  int cfg_sets    = 0;
  int deepest_bus = 0;

  pci_config_enumerator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scan predictor
  // --------------------------------------------------------------------------

  // Queue one output word; position fields are zero on a done word
  function automatic void expect_word(logic [1:0] kind, logic [7:0] off,
                                      logic [15:0] ven, logic [15:0] dev,
                                      logic [31:0] cls, logic [7:0] hdr,
                                      logic [16:0] cnt);
    out_word_t o;
    o = '0;
    o.kind = kind;
    if (kind != KIND_DONE) begin
      o.bus_number      = sc_bus;
      o.slot_number     = sc_slot;
      o.function_number = sc_func;
    end
    o.register_offset = off;
    o.vendor_code     = ven;
    o.device_code     = dev;
    o.class_register  = cls;
    o.hdr_byte        = hdr;
    o.device_count    = cnt;
    awaited_q.push_back(o);
  endfunction

  function automatic void request_read(phase_t nxt, logic [7:0] off);
    sc_ph = nxt;
    expect_word(KIND_REQ, off, '0, '0, '0, '0, '0);
  endfunction

  function automatic void finish_scan();
    sc_ph = PH_DONE;
    expect_word(KIND_DONE, '0, '0, '0, '0, '0, sc_count);
  endfunction

  function automatic void next_slot();
    sc_func = '0;
    if (sc_slot == LAST_SLOT) begin
      sc_slot = '0;
      if (sc_bus == LAST_BUS) begin
        sc_bus = '0;
        finish_scan();
        return;
      end
      sc_bus++;
    end else begin
      sc_slot++;
    end
    request_read(PH_F0ID, OFF_ID);
  endfunction

  function automatic void next_func();
    if ({1'b0, sc_func} + 4'd1 < sc_func_lim) begin
      sc_func++;
      request_read(PH_FNID, OFF_ID);
    end else begin
      next_slot();
    end
  endfunction

  function automatic logic filter_hit(logic [7:0] filt, logic [7:0] val);
    return filt == FILT_ANY || filt == val;
  endfunction

  // Advance the scan by one accepted input word
  function automatic void advance_scan(in_word_t w);
    logic [7:0] hdr;
    hdr = w.read_data[23:16];
    if (w.action == ACT_START) begin
      sc_bus      = '0;
      sc_slot     = '0;
      sc_func     = '0;
      sc_func_lim = FUNC_SINGLE;
      sc_count    = '0;
      request_read(PH_F0ID, OFF_ID);
      return;
    end
    case (sc_ph)
      PH_F0ID: begin
        if (w.read_data[15:0] == VENDOR_NONE) next_slot();
        else request_read(PH_F0HDR, OFF_HDR);
      end
      PH_F0HDR: begin
        sc_func_lim = w.read_data[HDR_MF_BIT] ? FUNC_MULTI : FUNC_SINGLE;
        sc_func     = '0;
        request_read(PH_FNID, OFF_ID);
      end
      PH_FNID: begin
        if (w.read_data[15:0] == VENDOR_NONE) begin
          next_func();
        end else begin
          sc_id = w.read_data;
          request_read(PH_FNCLS, OFF_CLASS);
        end
      end
      PH_FNCLS: begin
        sc_class = w.read_data;
        request_read(PH_FNHDR, OFF_HDR);
      end
      PH_FNHDR: begin
        if (filter_hit(scan_cfg.class_filter, sc_class[31:24]) &&
            filter_hit(scan_cfg.subclass_filter, sc_class[23:16]) &&
            filter_hit(scan_cfg.progif_filter, sc_class[15:8])) begin
          expect_word(KIND_REC, '0, sc_id[15:0], sc_id[31:16], sc_class, hdr, '0);
          if (sc_count != CNT_MAX) sc_count++;
          if (scan_cfg.stop_on_first) begin
            finish_scan();
            return;
          end
        end
        next_func();
      end
      default: ;  // idle or done: word is dropped
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Device population: a plausible answer to the read now pending
  // --------------------------------------------------------------------------
  function automatic logic [31:0] device_reply(int present_pct);
    logic [31:0] d;
    d = $urandom();
    case (sc_ph)
      PH_F0ID, PH_FNID: begin
        if ($urandom_range(99) >= present_pct) d[15:0] = VENDOR_NONE;
        else if (d[15:0] == VENDOR_NONE) d[0] = 1'b0;
      end
      PH_FNCLS: begin
        // lean toward the active filters so records show up
        if ($urandom_range(99) < 75) d[31:24] = scan_cfg.class_filter;
        if ($urandom_range(99) < 75) d[23:16] = scan_cfg.subclass_filter;
        if ($urandom_range(99) < 75) d[15:8]  = scan_cfg.progif_filter;
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] pick_filter();
    case ($urandom_range(2))
      0:       return FILT_ANY;
      1:       return 8'h00;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic cfg_t pick_config();
    cfg_t c;
    case ($urandom_range(3))
      0:       c = '{FILT_ANY, FILT_ANY, FILT_ANY, 1'b0};
      1:       c = '{8'h00, 8'h00, 8'h00, 1'b1};
      default: begin
        c.class_filter    = pick_filter();
        c.subclass_filter = pick_filter();
        c.progif_filter   = pick_filter();
        c.stop_on_first   = 1'($urandom_range(1));
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void diff_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic void check_result(out_word_t got);
    out_word_t want;
    case (got.kind)
      KIND_REQ:  n_req++;
      KIND_REC:  n_rec++;
      KIND_DONE: n_done++;
      default: ;
    endcase
    if (int'(got.bus_number) > deepest_bus) deepest_bus = int'(got.bus_number);
    if (awaited_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %p", $time, got);
      err_cnt++;
      return;
    end
    want = awaited_q.pop_front();
    diff_field("kind", 32'(want.kind), 32'(got.kind));
    diff_field("bus_number", 32'(want.bus_number), 32'(got.bus_number));
    diff_field("slot_number", 32'(want.slot_number), 32'(got.slot_number));
    diff_field("function_number", 32'(want.function_number),
               32'(got.function_number));
    diff_field("register_offset", 32'(want.register_offset),
               32'(got.register_offset));
    diff_field("vendor_code", 32'(want.vendor_code), 32'(got.vendor_code));
    diff_field("device_code", 32'(want.device_code), 32'(got.device_code));
    diff_field("class_register", want.class_register, got.class_register);
    diff_field("hdr_byte", 32'(want.hdr_byte), 32'(got.hdr_byte));
    diff_field("device_count", 32'(want.device_count), 32'(got.device_count));
  endfunction

  // Receiver: check accepted words, then choose next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_word);
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one word, hold it until taken, then predict its results
  task automatic send_word(input logic act, input logic [31:0] data);
    in_word_t w;
    w.action    = act;
    w.read_data = data;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    advance_scan(w);
  endtask

  // Start a new scan when the last one ended, else answer the pending read
  task automatic send_scan_item(input int present_pct);
    if (sc_ph == PH_IDLE || sc_ph == PH_DONE) send_word(ACT_START, $urandom());
    else send_word(ACT_REPLY, device_reply(present_pct));
  endtask

  // Wait for every owed word, then let the block go quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on back-to-back cycles; block must be quiet
  task automatic write_config(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CLASS;
    cfg_wdata <= c.class_filter;
    @(posedge clk);
    cfg_index <= CFG_SUBCLASS;
    cfg_wdata <= c.subclass_filter;
    @(posedge clk);
    cfg_index <= CFG_PROGIF;
    cfg_wdata <= c.progif_filter;
    @(posedge clk);
    cfg_index <= CFG_STOP;
    cfg_wdata <= {7'd0, c.stop_on_first};
    @(posedge clk);
    cfg_we    <= 1'b0;
    scan_cfg  = c;
    cfg_sets++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Responses before any start are dropped
  task automatic test_idle_replies();
    send_word(ACT_REPLY, 32'h0000_0000);
    send_word(ACT_REPLY, 32'hFFFF_FFFF);
    send_word(ACT_REPLY, $urandom());
    wait_drained();
  endtask

  // Reset filters: empty slot, multi-function device with absent functions,
  // field extremes, then a restart in the middle of a slot
  task automatic test_directed_walk();
    send_word(ACT_START, 32'hFFFF_FFFF);
    send_word(ACT_REPLY, 32'hFFFF_FFFF);   // slot 0 empty
    send_word(ACT_REPLY, 32'h0000_0000);   // slot 1, vendor 0
    send_word(ACT_REPLY, 32'h0080_0000);   // multi-function
    send_word(ACT_REPLY, 32'h0000_0000);
    send_word(ACT_REPLY, 32'hFFFF_FFFF);   // class all ones
    send_word(ACT_REPLY, 32'hFFFF_FFFF);   // record, header 0xFF
    send_word(ACT_REPLY, 32'hFFFF_FFFF);   // function 1 absent
    send_word(ACT_REPLY, 32'hABCD_1234);
    send_word(ACT_REPLY, 32'h0000_0000);   // class all zeros
    send_word(ACT_REPLY, 32'h0000_0000);   // record, header 0x00
    repeat (5) send_word(ACT_REPLY, 32'h1234_FFFF);  // functions 3..7 absent
    send_word(ACT_REPLY, 32'h5555_AAAA);   // slot 2 present
    send_word(ACT_START, 32'h0000_0000);   // restart mid scan
    send_word(ACT_REPLY, 32'h1111_2222);
    send_word(ACT_REPLY, 32'h007F_0000);   // single function
    send_word(ACT_REPLY, 32'h1111_2222);
    send_word(ACT_REPLY, 32'h0106_0102);
    send_word(ACT_REPLY, 32'h0000_0000);
    wait_drained();
  endtask

  // Exact filters with stop on first: a prog-if miss, then a hit ends the scan
  task automatic test_filter_stop();
    write_config('{8'h0C, 8'h03, 8'h30, 1'b1});
    send_word(ACT_START, $urandom());
    send_word(ACT_REPLY, 32'h0001_0002);
    send_word(ACT_REPLY, 32'h0000_0000);
    send_word(ACT_REPLY, 32'h5678_1AB4);
    send_word(ACT_REPLY, 32'h0C03_2001);   // prog-if differs
    send_word(ACT_REPLY, 32'h0000_0000);   // no record, next slot
    send_word(ACT_REPLY, 32'h0002_0003);
    send_word(ACT_REPLY, 32'h0080_0000);
    send_word(ACT_REPLY, 32'h0002_0003);
    send_word(ACT_REPLY, 32'h0C03_3010);   // all three match
    send_word(ACT_REPLY, 32'h00FF_0000);   // record then done
    send_word(ACT_REPLY, 32'h1234_5678);   // dropped after done
    wait_drained();
  endtask

  // Mostly well-formed answers with random content, some restarts and noise
  task automatic test_random_traffic(input int n_items);
    int sent;
    int next_cfg;
    int pick;
    sent     = 0;
    next_cfg = 0;
    while (sent < n_items) begin
      if (sent >= next_cfg) begin
        wait_drained();
        write_config(pick_config());
        next_cfg += CFG_EVERY;
      end
      if (sc_ph == PH_IDLE || sc_ph == PH_DONE) begin
        if ($urandom_range(3) == 0) begin
          send_word(ACT_REPLY, $urandom());  // dropped, not counted
        end else begin
          send_word(ACT_START, $urandom());
          sent++;
        end
      end else begin
        pick = $urandom_range(99);
        if (pick < 3) send_word(ACT_START, $urandom());
        else if (pick < 8) send_word(ACT_REPLY, $urandom());
        else send_word(ACT_REPLY, device_reply(55));
        sent++;
      end
    end
    wait_drained();
  endtask

  // Long receiver hold-off so the output queue fills and input stalls,
  // then a sender pause until the block has caught up
  task automatic test_queue_backpressure();
    write_config('{FILT_ANY, FILT_ANY, FILT_ANY, 1'b0});
    hold_len = 300;
    hold_seq++;
    repeat (60) send_scan_item(80);
    wait_drained();
    repeat (40) send_scan_item(80);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 16;
    rcv_idle_pct = 59;
    test_idle_replies();
    test_directed_walk();
    test_filter_stop();
    test_random_traffic(300);

    snd_idle_pct = 59;
    rcv_idle_pct = 16;
    test_random_traffic(300);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(250);
    test_queue_backpressure();

    wait_drained();
    $display("covered %0d input words over %0d filter settings, up to bus %0d",
             words_sent, cfg_sets, deepest_bus);
    $display("seen %0d read requests, %0d device records, %0d scan ends, %0d errors",
             n_req, n_rec, n_done, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_pci_config_enumerator: done, clean");
    end else begin
      $display("tb_pci_config_enumerator: done, errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d words outstanding", awaited_q.size());
    $display("tb_pci_config_enumerator: done, errors");
    $finish;
  end

endmodule
